// ----- hdl/stx_etx_dle_deframer_crc16_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the STX/ETX/DLE deframer
// Clocked concurrent checks with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_DLE_DEFRAMER_CRC16_TOP_MACROS_SVH
`define STX_ETX_DLE_DEFRAMER_CRC16_TOP_MACROS_SVH

// Same-cycle implication.
`define SEDD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SEDD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sedd_pkg.sv -----
// ----------------------------------------------------------------------------
// sedd_pkg
// Types, codes and widths shared by the deframer files.
// ----------------------------------------------------------------------------
package sedd_pkg;

  localparam int BUFFER_BYTES_DEF = 64;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int CRC_W        = 16;
  localparam int BYTE_W       = 8;
  localparam int EVENT_W      = 3;
  localparam int DATA_INDEX_W = 6;
  localparam int FRAME_LEN_W  = 7;

  localparam logic [CRC_W-1:0]  CRC_POLY_RST   = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT_RST   = 16'hFFFF;
  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;
  localparam logic [BYTE_W-1:0] ESC_CODE_RST   = 8'h10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CRC_POLY = 3'd0,
    CFG_CRC_INIT = 3'd1,
    CFG_START    = 3'd2,
    CFG_END      = 3'd3,
    CFG_ESCAPE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_SAVE   = 2'd1,
    MODE_UNMASK = 2'd2
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_GOOD     = 3'd2,
    EV_CRC_FAIL = 3'd3,
    EV_BAD      = 3'd4
  } event_t;

endpackage

// ----- hdl/sedd_if.sv -----
// ----------------------------------------------------------------------------
// sedd channel interfaces
// Valid/ready channels for configuration writes, received items and results.
// ----------------------------------------------------------------------------
interface sedd_cfg_if import sedd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface sedd_rx_if import sedd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface sedd_res_if import sedd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [EVENT_W-1:0]      event_res;
  logic [BYTE_W-1:0]       data_byte;
  logic [DATA_INDEX_W-1:0] data_index;
  logic [FRAME_LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0]       command_byte;
  logic                    send_ident;

  modport source (output valid, event_res, data_byte, data_index, frame_length,
                  command_byte, send_ident, input ready);
  modport sink   (input valid, event_res, data_byte, data_index, frame_length,
                  command_byte, send_ident, output ready);
endinterface

// ----- hdl/stx_etx_dle_deframer_crc16_top.sv -----
// Deframer for an STX/ETX framed byte stream with DLE escaping and a 16-bit
// CRC check. It takes one received byte (or receive-overflow item) per clock
// while rx.ready is high, and returns at most one result per item: the item
// is captured in an input register, goes through the parser and a one-byte
// CRC update in a single pass, and lands in the result register when the
// parser advances.
// rx.ready drops only while the input register holds an item that has a
// result and the result register is full and not being taken.
// ----------------------------------------------------------------------------
// stx_etx_dle_deframer_crc16_top
// Unescapes frame payload, tracks the CRC residue and reports frame events.
// ----------------------------------------------------------------------------
`include "stx_etx_dle_deframer_crc16_top_macros.svh"

module stx_etx_dle_deframer_crc16_top import sedd_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sedd_cfg_if.sink   cfg,
  sedd_rx_if.sink    rx,
  sedd_res_if.source res
);

  localparam int CountW = $clog2(BUFFER_BYTES + 1);

  // configuration
  logic [CRC_W-1:0]  crc_polynomial;
  logic [CRC_W-1:0]  crc_initial;
  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] end_code;
  logic [BYTE_W-1:0] escape_code;

  // input register
  logic              in_v;
  logic              in_kind;
  logic [BYTE_W-1:0] in_byte;

  // parser state
  mode_t             mode, mode_next;
  logic [CountW-1:0] count, count_next;
  logic [CRC_W-1:0]  crc, crc_next;
  logic              odd_start, odd_start_next;
  logic [BYTE_W-1:0] first_stored, first_stored_next;
  logic [BYTE_W-1:0] second_stored, second_stored_next;

  // result register
  logic                    out_v;
  logic [EVENT_W-1:0]      out_event;
  logic [BYTE_W-1:0]       out_data;
  logic [DATA_INDEX_W-1:0] out_index;
  logic [FRAME_LEN_W-1:0]  out_len;
  logic [BYTE_W-1:0]       out_cmd;
  logic                    out_ident;

  logic                    has_res;
  logic [EVENT_W-1:0]      ev_next;
  logic [BYTE_W-1:0]       data_next;
  logic [DATA_INDEX_W-1:0] index_next;
  logic [FRAME_LEN_W-1:0]  len_next;
  logic [BYTE_W-1:0]       cmd_next;
  logic                    ident_next;

  logic             do_store_req, do_start, do_end, do_bad, do_store;
  logic [CRC_W-1:0] crc_upd;
  logic             adv;

  sedd_crc_byte u_crc (
    .crc      (crc),
    .poly     (crc_polynomial),
    .data     (in_byte),
    .crc_next (crc_upd)
  );

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= CRC_POLY_RST;
      crc_initial    <= CRC_INIT_RST;
      start_code     <= START_CODE_RST;
      end_code       <= END_CODE_RST;
      escape_code    <= ESC_CODE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CRC_POLY: crc_polynomial <= cfg.data;
        CFG_CRC_INIT: crc_initial    <= cfg.data;
        CFG_START:    start_code     <= cfg.data[BYTE_W-1:0];
        CFG_END:      end_code       <= cfg.data[BYTE_W-1:0];
        CFG_ESCAPE:   escape_code    <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign adv      = in_v && (!out_v || res.ready || !has_res);
  assign rx.ready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (rx.ready) begin
      in_v <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_kind <= rx.kind;
      in_byte <= rx.rx_byte;
    end
  end

  // ---------------- parser ----------------
  always_comb begin
    do_store_req = 1'b0;
    do_start     = 1'b0;
    do_end       = 1'b0;
    mode_next    = mode;
    if (!in_kind) begin
      case (mode)
        MODE_UNMASK: begin
          do_store_req = 1'b1;
        end
        MODE_SAVE: begin
          // escape wins over start, start over end
          if (in_byte == escape_code) begin
            mode_next = MODE_UNMASK;
          end else if (in_byte == start_code) begin
            do_start = 1'b1;
          end else if (in_byte == end_code) begin
            do_end = 1'b1;
          end else begin
            do_store_req = 1'b1;
          end
        end
        default: begin
          if (in_byte == start_code) begin
            do_start = 1'b1;
          end
        end
      endcase
    end

    do_bad   = in_kind || (do_store_req && (count >= CountW'(BUFFER_BYTES)));
    do_store = do_store_req && !do_bad;

    count_next         = count;
    crc_next           = crc;
    odd_start_next     = odd_start;
    first_stored_next  = first_stored;
    second_stored_next = second_stored;
    has_res    = 1'b0;
    ev_next    = EV_NONE;
    data_next  = '0;
    index_next = '0;
    len_next   = '0;
    cmd_next   = '0;
    ident_next = 1'b0;

    if (do_bad) begin
      mode_next      = MODE_WAIT;
      count_next     = '0;
      crc_next       = crc_initial;
      odd_start_next = 1'b0;
      has_res        = 1'b1;
      ev_next        = EV_BAD;
      cmd_next       = second_stored;
    end else if (do_store) begin
      mode_next  = MODE_SAVE;
      count_next = count + CountW'(1);
      crc_next   = crc_upd;
      if (count == '0) begin
        first_stored_next = in_byte;
      end else if (count == CountW'(1)) begin
        second_stored_next = in_byte;
      end
      has_res    = 1'b1;
      ev_next    = EV_STORED;
      data_next  = in_byte;
      index_next = DATA_INDEX_W'(count);
    end else if (do_start) begin
      mode_next      = MODE_SAVE;
      count_next     = '0;
      crc_next       = crc_initial;
      odd_start_next = !odd_start;
      // second start of a pair asks for an identify reply
      if (odd_start) begin
        has_res    = 1'b1;
        ident_next = 1'b1;
      end
    end else if (do_end) begin
      mode_next      = MODE_WAIT;
      odd_start_next = 1'b0;
      has_res        = 1'b1;
      ev_next        = (crc == '0) ? EV_GOOD : EV_CRC_FAIL;
      len_next       = FRAME_LEN_W'(count);
      cmd_next       = first_stored;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_WAIT;
      count         <= '0;
      crc           <= CRC_INIT_RST;
      odd_start     <= 1'b0;
      first_stored  <= '0;
      second_stored <= '0;
    end else if (adv) begin
      mode          <= mode_next;
      count         <= count_next;
      crc           <= crc_next;
      odd_start     <= odd_start_next;
      first_stored  <= first_stored_next;
      second_stored <= second_stored_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv && has_res) begin
      out_v <= 1'b1;
    end else if (res.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_event <= ev_next;
      out_data  <= data_next;
      out_index <= index_next;
      out_len   <= len_next;
      out_cmd   <= cmd_next;
      out_ident <= ident_next;
    end
  end

  assign res.valid        = out_v;
  assign res.event_res    = out_event;
  assign res.data_byte    = out_data;
  assign res.data_index   = out_index;
  assign res.frame_length = out_len;
  assign res.command_byte = out_cmd;
  assign res.send_ident   = out_ident;

  // ---------------- assertions ----------------
  `SEDD_ASSERT_NEXT(a_bad_restarts, clk, rst, adv && do_bad, mode == MODE_WAIT && count == '0 && !odd_start && out_v, "bad packet did not restart the parser")
  `SEDD_ASSERT_NEXT(a_end_closes, clk, rst, adv && do_end, mode == MODE_WAIT && !odd_start && out_v, "frame end did not close the frame")
  `SEDD_ASSERT_NEXT(a_stall_holds_item, clk, rst, in_v && !adv, in_v && $stable(in_byte) && $stable(in_kind), "stalled input item lost")

endmodule

// ----- hdl/sedd_crc_byte.sv -----
// ----------------------------------------------------------------------------
// sedd_crc_byte
// One-byte update of a 16-bit MSB-first CRC with programmable polynomial.
// ----------------------------------------------------------------------------
module sedd_crc_byte import sedd_pkg::*; (
  input  logic [CRC_W-1:0]  crc,
  input  logic [CRC_W-1:0]  poly,
  input  logic [BYTE_W-1:0] data,
  output logic [CRC_W-1:0]  crc_next
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_next = c;
  end

endmodule

// ----- bench/stx_etx_dle_deframer_crc16_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stx_etx_dle_deframer_crc16_top_tb
// Drives framed byte streams, receive-overflow items and register writes into
// the deframer. A cycle-free model of the parser predicts every event, and
// each transfer on the result channel is checked against it in order.
// Covers escaping, CRC residue, identify requests, buffer limits, stale
// stored bytes, coinciding codes and a long result-side stall.
// ----------------------------------------------------------------------------
module stx_etx_dle_deframer_crc16_top_tb;
  import sedd_pkg::*;

  localparam int BUFFER_BYTES  = BUFFER_BYTES_DEF;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 10;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    event_t                  ev_code;
    logic [BYTE_W-1:0]       data_byte;
    logic [DATA_INDEX_W-1:0] data_index;
    logic [FRAME_LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0]       cmd_byte;
    logic                    ident;
  } deframe_res_t;

  logic clk;
  logic rst;

  sedd_cfg_if cfg_bus ();
  sedd_rx_if  rx_bus ();
  sedd_res_if res_bus ();

  stx_etx_dle_deframer_crc16_top #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .rx (rx_bus),
    .res(res_bus)
  );

  // parser model: registers
  logic [CRC_W-1:0]  poly_q = CRC_POLY_RST;
  logic [CRC_W-1:0]  init_q = CRC_INIT_RST;
  logic [BYTE_W-1:0] stx_q  = START_CODE_RST;
  logic [BYTE_W-1:0] etx_q  = END_CODE_RST;
  logic [BYTE_W-1:0] dle_q  = ESC_CODE_RST;

  // parser model: state
  mode_t             pmode       = MODE_WAIT;
  int unsigned       frame_count = 0;
  logic [CRC_W-1:0]  crc_q       = CRC_INIT_RST;
  bit                odd_start   = 1'b0;
  logic [BYTE_W-1:0] first_b     = '0;
  logic [BYTE_W-1:0] second_b    = '0;

  deframe_res_t pending_events[$];
  int           live_items = 0;
  int           err_count  = 0;
  bit           calm       = 1'b0;
  bit           hold_req   = 1'b0;
  int           hold_left  = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("stx_etx_dle_deframer_crc16_top_tb: done, errors");
    $finish;
  end

  function automatic logic [CRC_W-1:0] crc_next(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ poly_q) : (c << 1);
    return c;
  endfunction

  function automatic bit drop_frame(output deframe_res_t r);
    r = '0;
    r.ev_code = EV_BAD;
    r.cmd_byte = second_b;
    pmode = MODE_WAIT;
    frame_count = 0;
    crc_q = init_q;
    odd_start = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit store_byte(logic [BYTE_W-1:0] b, output deframe_res_t r);
    if (frame_count >= BUFFER_BYTES) return drop_frame(r);
    r = '0;
    if (frame_count == 0) first_b = b;
    else if (frame_count == 1) second_b = b;
    r.ev_code = EV_STORED;
    r.data_byte = b;
    r.data_index = frame_count[DATA_INDEX_W-1:0];
    frame_count++;
    crc_q = crc_next(crc_q, b);
    return 1'b1;
  endfunction

  function automatic bit open_frame(output deframe_res_t r);
    r = '0;
    odd_start = !odd_start;
    frame_count = 0;
    crc_q = init_q;
    pmode = MODE_SAVE;
    // every second start since the last end or drop asks for an identify reply
    r.ident = !odd_start;
    return !odd_start;
  endfunction

  function automatic void deframe_step(logic kind, logic [BYTE_W-1:0] b);
    deframe_res_t r;
    bit emits;
    r = '0;
    emits = 1'b0;
    if (kind || pmode != MODE_WAIT || b == stx_q) live_items++;
    if (kind) begin
      emits = drop_frame(r);
    end else begin
      case (pmode)
        MODE_UNMASK: begin
          pmode = MODE_SAVE;
          emits = store_byte(b, r);
        end
        MODE_SAVE: begin
          // escape wins over start, start over end
          if (b == dle_q) begin
            pmode = MODE_UNMASK;
          end else if (b == stx_q) begin
            emits = open_frame(r);
          end else if (b == etx_q) begin
            odd_start = 1'b0;
            pmode = MODE_WAIT;
            r.ev_code = (crc_q == '0) ? EV_GOOD : EV_CRC_FAIL;
            r.frame_len = frame_count[FRAME_LEN_W-1:0];
            r.cmd_byte = first_b;
            emits = 1'b1;
          end else begin
            emits = store_byte(b, r);
          end
        end
        default: begin
          if (b == stx_q) emits = open_frame(r);
        end
      endcase
    end
    if (emits) pending_events.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    deframe_res_t want;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual event %0d",
                 $time, res_bus.event_res);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 16'(want.ev_code), 16'(res_bus.event_res));
        check_field("data_byte", 16'(want.data_byte), 16'(res_bus.data_byte));
        check_field("data_index", 16'(want.data_index), 16'(res_bus.data_index));
        check_field("frame_length", 16'(want.frame_len), 16'(res_bus.frame_length));
        check_field("command_byte", 16'(want.cmd_byte), 16'(res_bus.command_byte));
        check_field("send_ident", 16'(want.ident), 16'(res_bus.send_ident));
      end
    end
  end

  // result side: random ready bursts, a long hold on request, none when calm
  initial begin : result_sink
    int  run_left;
    bit  run_ready;
    run_left = 0;
    run_ready = 1'b1;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (calm) begin
        res_bus.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 3) != 0);
          run_left = run_ready ? $urandom_range(1, 24) : $urandom_range(1, 11);
        end
        run_left--;
        res_bus.ready <= run_ready;
      end
    end
  end

  // valid stays high across back-to-back transfers; drop it only for a gap
  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.kind    <= kind;
    rx_bus.rx_byte <= b;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    deframe_step(kind, b);
  endtask

  function automatic byte_q_t random_payload(int len);
    byte_q_t p;
    for (int i = 0; i < len; i++) p.push_back(BYTE_W'($urandom_range(0, 255)));
    return p;
  endfunction

  task automatic send_frame(input byte_q_t payload, input bit crc_ok, input bit closed);
    logic [CRC_W-1:0] crc;
    byte_q_t body;
    crc = init_q;
    foreach (payload[i]) crc = crc_next(crc, payload[i]);
    if (!crc_ok) crc ^= 16'h1 << $urandom_range(0, 15);
    body = payload;
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    send_item(1'b0, stx_q);
    foreach (body[i]) begin
      // escape every code byte, and now and then a plain one
      if (body[i] == dle_q || body[i] == stx_q || body[i] == etx_q ||
          $urandom_range(0, 11) == 0)
        send_item(1'b0, dle_q);
      send_item(1'b0, body[i]);
    end
    if (closed) send_item(1'b0, etx_q);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    rx_bus.valid <= 1'b0;
    while (pending_events.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_events.size() != 0) begin
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, pending_events.size());
      err_count++;
      pending_events.delete();
    end
    // let items that cause no result clear the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CRC_W-1:0] poly, init,
                          input logic [BYTE_W-1:0] s, e, d);
    cfg_reg_t    idx;
    logic [15:0] vals [5];
    vals = '{poly, init, {8'h00, s}, {8'h00, e}, {8'h00, d}};
    for (int i = 0; i < 5; i++) begin
      idx = cfg_reg_t'(i);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= vals[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      case (idx)
        CFG_CRC_POLY: poly_q = vals[i];
        CFG_CRC_INIT: init_q = vals[i];
        CFG_START:    stx_q  = vals[i][7:0];
        CFG_END:      etx_q  = vals[i][7:0];
        CFG_ESCAPE:   dle_q  = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_directed();
    byte_q_t p;
    // code bytes as payload, all escaped
    p = '{8'h00, 8'hFF, START_CODE_RST, END_CODE_RST, ESC_CODE_RST};
    send_frame(p, 1'b1, 1'b1);
    // two starts ask for identify; the empty frame reports the stale first byte
    send_item(1'b0, stx_q);
    send_item(1'b0, stx_q);
    send_item(1'b0, etx_q);
    p = '{8'hA5};
    send_frame(p, 1'b0, 1'b1);
    // data and end bytes are ignored while waiting for a start
    send_item(1'b0, 8'h41);
    send_item(1'b0, etx_q);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, stx_q);
    send_item(1'b0, 8'h11);
    send_item(1'b0, 8'h22);
    send_item(1'b1, 8'h00);
    wait_idle();
  endtask

  task automatic test_buffer_limits();
    // 62 payload plus 2 CRC bytes fill the buffer exactly
    send_frame(random_payload(BUFFER_BYTES - 2), 1'b1, 1'b1);
    send_frame(random_payload(BUFFER_BYTES), 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    wait (hold_left > 0);
    send_frame(random_payload(40), 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_frames(input logic [CRC_W-1:0] poly, init,
                                    input logic [BYTE_W-1:0] s, e, d,
                                    input int n_live);
    int stop_at;
    int pick;
    int len;
    wait_idle();
    set_regs(poly, init, s, e, d);
    stop_at = live_items + n_live;
    while (live_items < stop_at) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 16);
      if (pick < 70) begin
        send_frame(random_payload(len), $urandom_range(0, 4) != 0, 1'b1);
      end else if (pick < 78) begin
        send_item(1'b0, stx_q);
        send_frame(random_payload(len), 1'b1, 1'b1);
      end else if (pick < 85) begin
        send_frame(random_payload(len), 1'b1, 1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 5))
            0: send_item(1'b0, stx_q);
            1: send_item(1'b0, etx_q);
            2: send_item(1'b0, dle_q);
            default: send_item($urandom_range(0, 15) == 0, BYTE_W'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_CRC_POLY;
    cfg_bus.data   <= '0;
    rx_bus.valid   <= 1'b0;
    rx_bus.kind    <= 1'b0;
    rx_bus.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_buffer_limits();
    test_backpressure();
    test_random_frames(16'hFFFF, 16'h0000, 8'h00, 8'hFF, 8'h7E, 170);
    test_random_frames(16'h0000, 16'hFFFF, 8'hFF, 8'h00, 8'h80, 170);
    test_random_frames(CRC_W'($urandom_range(0, 65535)), CRC_W'($urandom_range(0, 65535)),
                       8'h2A, 8'hD5, 8'h55, 170);
    // start equals end: start wins, frames only end on overflow
    test_random_frames(16'h8005, 16'h1D0F, 8'h5A, 8'h5A, 8'hA5, 150);
    // end equals escape: escape wins
    test_random_frames(16'h1021, 16'hFFFF, 8'hC3, 8'h3C, 8'h3C, 150);
    // start equals escape: start only works while waiting
    test_random_frames(16'h1021, 16'h0000, 8'h10, 8'h03, 8'h10, 150);
    calm = 1'b1;
    test_random_frames(CRC_POLY_RST, CRC_INIT_RST, START_CODE_RST, END_CODE_RST,
                       ESC_CODE_RST, 200);
    wait_idle();

    if (err_count == 0) begin
      $display("stx_etx_dle_deframer_crc16_top_tb: done, clean");
    end else begin
      $display("stx_etx_dle_deframer_crc16_top_tb: done, errors");
    end
    $finish;
  end

endmodule
